// ----- rtl/sgf_pkg.sv -----
// Shared types and constants for the Scharr gradient filter.
`timescale 1ns / 1ps

package sgf_pkg;

    localparam int PIX_W      = 8;
    localparam int H_W        = 12;
    localparam int ROW_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int WIDTH_CFG_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    localparam logic [H_W-1:0] RST_HEIGHT = 12'd480;
    localparam int             RST_WIDTH  = 640;
    localparam int             MIN_DIM    = 3;

    // border flags of the centre pixel a result belongs to
    typedef struct packed {
        logic top;
        logic bottom;
        logic left_col;
        logic right_col;
        logic last;
    } border_t;

    typedef struct packed {
        logic             emit;
        logic [PIX_W-1:0] pix;
        border_t          border;
    } sgf_item_t;

    // [row][col], row 0 on top, col 0 on the left
    typedef logic [2:0][2:0][PIX_W-1:0] window_t;

endpackage

// ----- rtl/sgf_if.sv -----
// Channel interfaces: pixel input, gradient output, configuration writes.
`timescale 1ns / 1ps

interface sgf_pix_if;
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic [sgf_pkg::PIX_W-1:0] pixel;

    modport source (output valid, req_type, pixel, input ready);
    modport sink   (input valid, req_type, pixel, output ready);
endinterface

interface sgf_grad_if;
    logic                      valid;
    logic                      ready;
    logic [sgf_pkg::PIX_W-1:0] grad_x_byte;
    logic [sgf_pkg::PIX_W-1:0] grad_y_byte;
    logic                      last_of_frame;

    modport source (output valid, grad_x_byte, grad_y_byte, last_of_frame, input ready);
    modport sink   (input valid, grad_x_byte, grad_y_byte, last_of_frame, output ready);
endinterface

interface sgf_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [sgf_pkg::CFG_IDX_W-1:0]  index;
    logic [sgf_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/sgf_ctrl.sv -----
// Frame registers, raster counters and per-item border flags.
`timescale 1ns / 1ps

module sgf_ctrl #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    sgf_cfg_if.sink                    cfg,
    sgf_pix_if.sink                    pix_in,
    output logic                       item_valid,
    output sgf_pkg::sgf_item_t         item,
    output logic [$clog2(MAX_WIDTH)-1:0] item_col,
    input  logic                       item_ready
);
    import sgf_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int EXW = ((WW > WIDTH_CFG_W) ? WW : WIDTH_CFG_W) + 1;
    localparam int RST_W_VAL = (RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH;
    localparam logic [EXW-1:0] MAXW_EXT = EXW'(MAX_WIDTH);
    localparam logic [EXW-1:0] MINW_EXT = EXW'(MIN_DIM);

    logic [WW-1:0]    w_reg, w_next;
    logic [H_W-1:0]   h_reg, h_next;
    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [CW-1:0]    qc_reg, qc_next;
    logic [H_W-1:0]   qr_reg, qr_next;

    logic           in_frame;
    logic           is_flush;
    logic           ignore_item;
    logic           take;
    logic [CW-1:0]  w_last;
    logic           col_wrap;
    logic           emit;
    border_t        border;
    logic [EXW-1:0] w_cfg;
    logic [H_W-1:0] h_cfg;

    assign in_frame    = row_reg < {1'b0, h_reg};
    assign is_flush    = pix_in.req_type == REQ_FLUSH;
    assign ignore_item = in_frame && is_flush;
    assign w_last      = CW'(w_reg - WW'(1));
    assign col_wrap    = col_reg == w_last;
    // first result with the second item of the row below the first pixel
    assign emit        = (row_reg >= ROW_W'(2)) || (row_reg == ROW_W'(1) && col_reg != '0);

    assign border.top       = qr_reg == '0;
    assign border.bottom    = qr_reg == h_reg - H_W'(1);
    assign border.left_col  = qc_reg == '0;
    assign border.right_col = qc_reg == w_last;
    assign border.last      = border.bottom && border.right_col;

    assign item.emit   = emit;
    assign item.pix    = in_frame ? pix_in.pixel : '0;
    assign item.border = border;
    assign item_col    = col_reg;
    assign item_valid  = pix_in.valid && !ignore_item;

    assign pix_in.ready = item_ready;
    assign cfg.ready    = 1'b1;

    assign take = pix_in.valid && item_ready && !ignore_item;

    always_comb
    begin
        w_cfg = {(EXW - WIDTH_CFG_W)'(0), cfg.data[WIDTH_CFG_W-1:0]};
        if (w_cfg < MINW_EXT)
        begin
            w_cfg = MINW_EXT;
        end
        if (w_cfg > MAXW_EXT)
        begin
            w_cfg = MAXW_EXT;
        end
        h_cfg = cfg.data[H_W-1:0];
        if (h_cfg < H_W'(MIN_DIM))
        begin
            h_cfg = H_W'(MIN_DIM);
        end
    end

    always_comb
    begin
        w_next   = w_reg;
        h_next   = h_reg;
        col_next = col_reg;
        row_next = row_reg;
        qc_next  = qc_reg;
        qr_next  = qr_reg;
        if (cfg.valid && (cfg.index == CFG_FRAME_WIDTH || cfg.index == CFG_FRAME_HEIGHT))
        begin
            if (cfg.index == CFG_FRAME_WIDTH)
            begin
                w_next = WW'(w_cfg);
            end
            else
            begin
                h_next = h_cfg;
            end
            col_next = '0;
            row_next = '0;
            qc_next  = '0;
            qr_next  = '0;
        end
        else if (take)
        begin
            if (emit && border.last)
            begin
                col_next = '0;
                row_next = '0;
                qc_next  = '0;
                qr_next  = '0;
            end
            else
            begin
                if (col_wrap)
                begin
                    col_next = '0;
                    row_next = row_reg + ROW_W'(1);
                end
                else
                begin
                    col_next = col_reg + CW'(1);
                end
                if (emit)
                begin
                    if (border.right_col)
                    begin
                        qc_next = '0;
                        qr_next = qr_reg + H_W'(1);
                    end
                    else
                    begin
                        qc_next = qc_reg + CW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg   <= WW'(RST_W_VAL);
            h_reg   <= RST_HEIGHT;
            col_reg <= '0;
            row_reg <= '0;
            qc_reg  <= '0;
            qr_reg  <= '0;
        end
        else
        begin
            w_reg   <= w_next;
            h_reg   <= h_next;
            col_reg <= col_next;
            row_reg <= row_next;
            qc_reg  <= qc_next;
            qr_reg  <= qr_next;
        end
    end

endmodule

// ----- rtl/sgf_line_mem.sv -----
// Line store memory (upper and middle rows side by side) and the 3x3 window.
`timescale 1ns / 1ps

module sgf_line_mem #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    input  sgf_pkg::sgf_item_t           item,
    input  logic [$clog2(MAX_WIDTH)-1:0] item_col,
    output logic                         item_ready,
    output logic                         win_valid,
    output sgf_pkg::window_t             window,
    output sgf_pkg::border_t             border,
    input  logic                         win_ready
);
    import sgf_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    // entry = {upper row pixel, middle row pixel}
    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_reg;

    logic             v1_reg;
    logic [PIX_W-1:0] pix1_reg;
    logic [CW-1:0]    col1_reg;
    logic             emit1_reg;
    border_t          border1_reg;

    logic    v2_reg;
    window_t win_reg;
    border_t border2_reg;

    logic             accept;
    logic             free2;
    logic             adv1;
    logic [PIX_W-1:0] top_pix;
    logic [PIX_W-1:0] mid_pix;

    assign free2      = !v2_reg || win_ready;
    assign adv1       = v1_reg && free2;
    assign item_ready = !v1_reg || free2;
    assign accept     = item_valid && item_ready;

    assign top_pix = rd_reg[2*PIX_W-1:PIX_W];
    assign mid_pix = rd_reg[PIX_W-1:0];

    // one read on accept, one write-back as the item leaves; within a frame the
    // addresses of two items in flight differ since a row holds at least 3, and
    // across a frame restart the entry read only feeds rows above the frame
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg <= line_mem[item_col];
        end
        if (adv1)
        begin
            line_mem[col1_reg] <= {mid_pix, pix1_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                v1_reg <= 1'b1;
            end
            else if (adv1)
            begin
                v1_reg <= 1'b0;
            end
            if (adv1)
            begin
                v2_reg <= emit1_reg;
            end
            else if (win_ready)
            begin
                v2_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix1_reg    <= item.pix;
            col1_reg    <= item_col;
            emit1_reg   <= item.emit;
            border1_reg <= item.border;
        end
        if (adv1)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= top_pix;
            win_reg[1][2] <= mid_pix;
            win_reg[2][2] <= pix1_reg;
            border2_reg   <= border1_reg;
        end
    end

    assign win_valid = v2_reg;
    assign window    = win_reg;
    assign border    = border2_reg;

endmodule

// ----- rtl/sgf_grad.sv -----
// Border masking, gradient differences and the scaled output bytes.
`timescale 1ns / 1ps

module sgf_grad (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             win_valid,
    input  sgf_pkg::window_t window,
    input  sgf_pkg::border_t border,
    output logic             win_ready,
    sgf_grad_if.source       grad_out
);
    import sgf_pkg::*;

    window_t            m;
    logic signed [8:0]  ax, ay, d1, d2;
    logic signed [9:0]  sx, sy;

    logic               v3_reg;
    logic signed [8:0]  ax_reg, ay_reg;
    logic signed [9:0]  sx_reg, sy_reg;
    logic               last3_reg;

    logic               ov_reg;
    logic [PIX_W-1:0]   gx_byte_reg, gy_byte_reg;
    logic               last_reg;

    logic               free_out;
    logic               free3;
    logic signed [18:0] gx, gy;

    assign free_out  = !ov_reg || grad_out.ready;
    assign free3     = !v3_reg || free_out;
    assign win_ready = free3;

    // neighbours outside the frame read as zero
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if ((r == 0 && border.top) || (r == 2 && border.bottom) ||
                    (c == 0 && border.left_col) || (c == 2 && border.right_col))
                begin
                    m[r][c] = '0;
                end
                else
                begin
                    m[r][c] = window[r][c];
                end
            end
        end
    end

    assign ax = $signed({1'b0, m[1][0]}) - $signed({1'b0, m[1][2]});
    assign ay = $signed({1'b0, m[0][1]}) - $signed({1'b0, m[2][1]});
    assign d1 = $signed({1'b0, m[0][0]}) - $signed({1'b0, m[2][2]});
    assign d2 = $signed({1'b0, m[2][0]}) - $signed({1'b0, m[0][2]});
    assign sx = 10'(d1) + 10'(d2);
    assign sy = 10'(d1) - 10'(d2);

    // sum stays in [256, 130816], so bits 16:9 are the byte
    assign gx = 19'(ax_reg) * 19'sd162 + 19'(sx_reg) * 19'sd47 + 19'sd65536;
    assign gy = 19'(ay_reg) * 19'sd162 + 19'(sy_reg) * 19'sd47 + 19'sd65536;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (free3)
            begin
                v3_reg <= win_valid;
            end
            if (free_out)
            begin
                ov_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (free3 && win_valid)
        begin
            ax_reg    <= ax;
            ay_reg    <= ay;
            sx_reg    <= sx;
            sy_reg    <= sy;
            last3_reg <= border.last;
        end
        if (free_out && v3_reg)
        begin
            gx_byte_reg <= gx[16:9];
            gy_byte_reg <= gy[16:9];
            last_reg    <= last3_reg;
        end
    end

    assign grad_out.valid         = ov_reg;
    assign grad_out.grad_x_byte   = gx_byte_reg;
    assign grad_out.grad_y_byte   = gy_byte_reg;
    assign grad_out.last_of_frame = last_reg;

endmodule

// ----- rtl/scharr_gradient_filter.sv -----
// Top level of the Scharr 3x3 gradient filter.
`timescale 1ns / 1ps

// Takes one 8-bit grey pixel per clock in raster order and returns, for each
// frame pixel, the horizontal and vertical Scharr gradients as bytes offset
// by 128, neighbours outside the frame counting as zero. Sustained rate is
// one item per cycle unless grad_out stalls: the line store is a single
// memory holding the upper and middle rows side by side, read once when an
// item is accepted and written back once when it moves into the window, so
// each item costs one read and one write. A result comes out after the item
// that completes its neighbourhood, which is one row plus one pixel after
// its centre pixel; after the frame, frame_width + 1 further items (flush or
// pixel) drain the last row, the final result being marked last_of_frame.
// Flush items sent while the frame is still arriving are taken and dropped.
// Writing frame_width or frame_height restarts the frame; write them only
// while no results are outstanding. MAX_WIDTH sets the line store depth.
module scharr_gradient_filter #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    sgf_cfg_if.sink     cfg,
    sgf_pix_if.sink     pix_in,
    sgf_grad_if.source  grad_out
);
    import sgf_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic          item_valid;
    logic          item_ready;
    sgf_item_t     item;
    logic [CW-1:0] item_col;

    logic    win_valid;
    logic    win_ready;
    window_t window;
    border_t border;

    sgf_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .pix_in     (pix_in),
        .item_valid (item_valid),
        .item       (item),
        .item_col   (item_col),
        .item_ready (item_ready)
    );

    sgf_line_mem #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_col   (item_col),
        .item_ready (item_ready),
        .win_valid  (win_valid),
        .window     (window),
        .border     (border),
        .win_ready  (win_ready)
    );

    sgf_grad u_grad (
        .clk       (clk),
        .rst_n     (rst_n),
        .win_valid (win_valid),
        .window    (window),
        .border    (border),
        .win_ready (win_ready),
        .grad_out  (grad_out)
    );

    // a stalled window keeps its border flags
    a_win_hold: assert property (@(posedge clk) disable iff (!rst_n)
        win_valid && !win_ready |=> win_valid && $stable(border))
        else $error("window stage lost its item under stall");

    // a frame is at least three rows and three columns
    a_rows_apart: assert property (@(posedge clk) disable iff (!rst_n)
        win_valid |-> !(border.top && border.bottom))
        else $error("top and bottom border on the same result");

    a_cols_apart: assert property (@(posedge clk) disable iff (!rst_n)
        win_valid |-> !(border.left_col && border.right_col))
        else $error("left and right border on the same result");

endmodule
